### rtl/conv3x3_image_filter_defines.svh
// ----------------------------------------------------------------------------
// conv3x3_image_filter assertion macros
// Shared assertion forms for the 3x3 convolution filter.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_IMAGE_FILTER_DEFINES_SVH
`define CONV3X3_IMAGE_FILTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CIF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("conv3x3_image_filter: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CIF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("conv3x3_image_filter: next-cycle check failed");

`endif

### rtl/cif_pkg.sv
// ----------------------------------------------------------------------------
// cif_pkg
// Types, constants and arithmetic helpers of the 3x3 convolution filter.
// ----------------------------------------------------------------------------
package cif_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int COL_W      = $clog2(MAX_WIDTH + 1);
  localparam int FW_W       = 11;
  localparam int ROW_W      = 16;
  localparam int CMP_W      = (COL_W > FW_W) ? COL_W : FW_W;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = CH_W * NUM_CH;
  localparam int LINE_W     = 2 * PIX_W;
  localparam int TAP_W      = 16;
  localparam int COEF_W     = 3 * TAP_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;
  localparam int PROD_W     = CH_W + TAP_W;
  localparam int RSUM_W     = PROD_W + 2;
  localparam int TSUM_W     = PROD_W + 4;
  localparam int FRAC_W     = 12;

  localparam logic [COEF_W-1:0] COEF_OUTER_RST = 48'h0100_0200_0100;
  localparam logic [COEF_W-1:0] COEF_MID_RST   = 48'h0200_0400_0200;
  localparam logic [FW_W-1:0]   FW_RST         = 11'd1024;
  localparam logic [ROW_W-1:0]  FH_RST         = 16'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_COLOR_MODE,
    REG_COEF_TOP,
    REG_COEF_MID,
    REG_COEF_BOTTOM
  } cfg_reg_t;

  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RSUM_W-1:0] rsum_t;
  typedef logic signed [TSUM_W-1:0] tsum_t;

  typedef struct packed {
    logic [CH_W-1:0] in_chan0;
    logic [CH_W-1:0] in_chan1;
    logic [CH_W-1:0] in_chan2;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_chan0;
    logic [CH_W-1:0] out_chan1;
    logic [CH_W-1:0] out_chan2;
    logic            last_pixel;
  } out_item_t;

  // Unsigned pixel channel times signed Q3.12 tap.
  function automatic prod_t mul_tap(logic [CH_W-1:0] v, logic signed [TAP_W-1:0] t);
    logic signed [PROD_W:0] full;
    full = $signed({1'b0, v}) * t;
    return $signed(full[PROD_W-1:0]);
  endfunction

  // Drop the fraction and clamp to 0..255.
  function automatic logic [CH_W-1:0] sat_q12(tsum_t s);
    logic [CH_W-1:0] res;
    if (s[TSUM_W-1]) begin
      res = '0;
    end else if (s[TSUM_W-2:FRAC_W+CH_W] != '0) begin
      res = '1;
    end else begin
      res = s[FRAC_W+CH_W-1:FRAC_W];
    end
    return res;
  endfunction

endpackage

### rtl/conv3x3_image_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_image_filter
// 3x3 convolution over a raster-scanned RGB or grey image, zero padded.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     in_data  (in_item_t)
//   out      output     out_valid / out_stall   out_data (out_item_t)
//   cfg      input      cfg_wr_en               cfg_index, cfg_wdata
//
// One scanned pixel is taken per cycle while in_stall is low; its result, if
// any, reaches the output register through the stage 1, 2 and 3 registers
// (line store read at the transfer, then multiply, row sums, final sum and
// clamp). The line store RAM has one read and one write port: a pixel's
// column is read at the transfer and written back from stage 1.
// After reset a clearing pass writes zero to all 1024 line store entries;
// no input is taken meanwhile. A full skid register holds the whole pipeline
// until the output drains.
// ----------------------------------------------------------------------------
`include "conv3x3_image_filter_defines.svh"

module conv3x3_image_filter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cif_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output cif_pkg::out_item_t               out_data,
  input  logic                             cfg_wr_en,
  input  logic [cif_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cif_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import cif_pkg::*;

  // configuration
  logic [FW_W-1:0]   frame_width_r;
  logic [ROW_W-1:0]  frame_height_r;
  logic              color_mode_r;
  logic [COEF_W-1:0] coef_r [3];

  // scan position and clearing pass
  logic [COL_W-1:0]  scan_col_r;
  logic [ROW_W-1:0]  scan_row_r;
  logic              clr_active_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  logic              adv;
  logic              in_accept;

  logic [CMP_W-1:0]  fw_ext;
  logic [CMP_W-1:0]  w_cmp;
  logic [COL_W-1:0]  w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic [ROW_W:0]    row_inc;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  scan_col_nxt;
  logic [ROW_W-1:0]  scan_row_nxt;
  logic              cur_cin;
  pix_t              cur_px;

  // stage 1: line store data back
  logic              s1_valid_r;
  pix_t              s1_px_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              s1_cin_r;
  logic              s1_r0_r;
  logic              s1_c0_r;
  logic              s1_emit_r;
  logic              s1_last_r;

  // line store RAM port signals
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [LINE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [LINE_W-1:0] mem_rdata;
  pix_t              rd_prev;
  pix_t              rd_prev2;

  pix_t              win_r [6];
  pix_t              col [3];
  pix_t              wl [3];
  pix_t              wm [3];
  prod_t             prod [NUM_CH][3][3];

  // stage 2: products
  logic              s2_valid_r;
  logic              s2_emit_r;
  logic              s2_last_r;
  prod_t             prod_r [NUM_CH][3][3];
  rsum_t             rsum [NUM_CH][3];

  // stage 3: row sums
  logic              s3_valid_r;
  logic              s3_emit_r;
  logic              s3_last_r;
  rsum_t             rsum_r [NUM_CH][3];
  tsum_t             tsum [NUM_CH];
  out_item_t         result;

  // output register and skid
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_item_t         out_data_r;
  out_item_t         out_data_nxt;
  logic              skid_valid_r;
  logic              skid_valid_nxt;
  out_item_t         skid_data_r;
  out_item_t         skid_data_nxt;
  logic              up_valid;
  logic              out_fire;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RST;
      frame_height_r <= FH_RST;
      color_mode_r   <= 1'b0;
      coef_r[0]      <= COEF_OUTER_RST;
      coef_r[1]      <= COEF_MID_RST;
      coef_r[2]      <= COEF_OUTER_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[ROW_W-1:0];
        REG_COLOR_MODE:   color_mode_r   <= cfg_wdata[0];
        REG_COEF_TOP:     coef_r[0]      <= cfg_wdata[COEF_W-1:0];
        REG_COEF_MID:     coef_r[1]      <= cfg_wdata[COEF_W-1:0];
        REG_COEF_BOTTOM:  coef_r[2]      <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: scan position, input transfer, line store read
  // --------------------------------------------------------------------------
  assign adv       = !skid_valid_r;
  assign in_stall  = !adv || clr_active_r;
  assign in_accept = in_valid && !in_stall;

  assign fw_ext = CMP_W'(frame_width_r);
  assign h_eff  = (frame_height_r == '0) ? ROW_W'(1) : frame_height_r;

  always_comb begin
    if (fw_ext == '0) begin
      w_cmp = CMP_W'(1);
    end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
      w_cmp = CMP_W'(MAX_WIDTH);
    end else begin
      w_cmp = fw_ext;
    end
  end
  assign w_eff = COL_W'(w_cmp);

  always_comb begin
    // a position left beyond the grid by a register change wraps first
    if (scan_col_r > w_eff) begin
      cur_col = '0;
      row_inc = {1'b0, scan_row_r} + (ROW_W+1)'(1);
    end else begin
      cur_col = scan_col_r;
      row_inc = {1'b0, scan_row_r};
    end
    cur_row = (row_inc > {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];

    if (cur_col >= w_eff) begin
      scan_col_nxt = '0;
      scan_row_nxt = (cur_row >= h_eff) ? '0 : cur_row + ROW_W'(1);
    end else begin
      scan_col_nxt = cur_col + COL_W'(1);
      scan_row_nxt = cur_row;
    end
  end

  assign cur_cin = cur_col < w_eff;
  assign cur_px  = (cur_cin && cur_row < h_eff) ?
                   {in_data.in_chan2, in_data.in_chan1, in_data.in_chan0} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_col_r <= '0;
      scan_row_r <= '0;
    end else if (in_accept) begin
      scan_col_r <= scan_col_nxt;
      scan_row_r <= scan_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      if (clr_cnt_r == ADDR_W'(MAX_WIDTH - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px_r   <= cur_px;
      s1_addr_r <= cur_col[ADDR_W-1:0];
      s1_cin_r  <= cur_cin;
      s1_r0_r   <= cur_row == '0;
      s1_c0_r   <= cur_col == '0;
      s1_emit_r <= (cur_row != '0) && (cur_col != '0);
      s1_last_r <= (cur_row == h_eff) && (cur_col == w_eff);
    end
  end

  // --------------------------------------------------------------------------
  // Line store: {row r-2, row r-1} per column
  // --------------------------------------------------------------------------
  assign mem_re    = in_accept;
  assign mem_raddr = cur_col[ADDR_W-1:0];
  assign rd_prev   = mem_rdata[PIX_W-1:0];
  assign rd_prev2  = mem_rdata[LINE_W-1:PIX_W];

  always_comb begin
    if (clr_active_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      // shift the column down one row and store the new pixel
      mem_we    = s1_valid_r && adv && s1_cin_r;
      mem_waddr = s1_addr_r;
      mem_wdata = {rd_prev, s1_px_r};
    end
  end

  cif_ram #(
    .DATA_W (LINE_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage 1: window assembly and tap products
  // --------------------------------------------------------------------------
  always_comb begin
    // rows above the frame and the column past the edge read as zero
    col[0] = (s1_r0_r || !s1_cin_r) ? '0 : rd_prev2;
    col[1] = (s1_r0_r || !s1_cin_r) ? '0 : rd_prev;
    col[2] = s1_px_r;
    for (int k = 0; k < 3; k++) begin
      wl[k] = s1_c0_r ? '0 : win_r[k];
      wm[k] = s1_c0_r ? '0 : win_r[3+k];
    end
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int k = 0; k < 3; k++) begin
        prod[ch][k][0] = mul_tap(wl[k][CH_W*ch +: CH_W],
                                 $signed(coef_r[k][0 +: TAP_W]));
        prod[ch][k][1] = mul_tap(wm[k][CH_W*ch +: CH_W],
                                 $signed(coef_r[k][TAP_W +: TAP_W]));
        prod[ch][k][2] = mul_tap(col[k][CH_W*ch +: CH_W],
                                 $signed(coef_r[k][2*TAP_W +: TAP_W]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && adv) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k]   <= wm[k];
        win_r[3+k] <= col[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_emit_r <= s1_emit_r;
      s2_last_r <= s1_last_r;
      prod_r    <= prod;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: per-row sums
  // --------------------------------------------------------------------------
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int k = 0; k < 3; k++) begin
        rsum[ch][k] = RSUM_W'(prod_r[ch][k][0]) + RSUM_W'(prod_r[ch][k][1])
                    + RSUM_W'(prod_r[ch][k][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_emit_r <= s2_emit_r;
      s3_last_r <= s2_last_r;
      rsum_r    <= rsum;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: final sum and clamp
  // --------------------------------------------------------------------------
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      tsum[ch] = TSUM_W'(rsum_r[ch][0]) + TSUM_W'(rsum_r[ch][1])
               + TSUM_W'(rsum_r[ch][2]);
    end
    result.out_chan0  = sat_q12(tsum[0]);
    result.out_chan1  = color_mode_r ? sat_q12(tsum[1]) : '0;
    result.out_chan2  = color_mode_r ? sat_q12(tsum[2]) : '0;
    result.last_pixel = s3_last_r;
  end

  // --------------------------------------------------------------------------
  // Output register with skid
  // --------------------------------------------------------------------------
  assign up_valid = s3_valid_r && s3_emit_r && adv;
  assign out_fire = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_fire) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (up_valid) begin
      if (!out_valid_r || out_fire) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = result;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CIF_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `CIF_ASSERT_IMP(a_no_same_entry_rmw, clk, rst_n, mem_we && mem_re, mem_waddr != mem_raddr)
  `CIF_ASSERT_NXT(a_stage1_advances, clk, rst_n, s1_valid_r && adv, s2_valid_r)

endmodule

### rtl/cif_ram.sv
// ----------------------------------------------------------------------------
// cif_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cif_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the last read word while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### bench/tb_conv3x3_image_filter.sv
// ----------------------------------------------------------------------------
// tb_conv3x3_image_filter
// Self-checking bench for the 3x3 convolution filter. A predictor with its
// own line stores, window and scan position works out each filtered pixel
// from the accepted input stream. A monitor compares every output transfer
// with the oldest expected pixel. Directed frames cover the extreme sizes,
// taps and pixel values and a scan left beyond a shrunk grid. Random frames
// follow, under several idle and stall profiles and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_conv3x3_image_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import cif_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int RANDOM_ITEMS   = 240;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  conv3x3_image_filter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Filter state as the predictor sees it
  logic [FW_W-1:0]   width_reg;
  logic [ROW_W-1:0]  height_reg;
  bit                rgb_mode;
  logic [COEF_W-1:0] coef_rows [3];
  logic [PIX_W-1:0]  prior_row [MAX_WIDTH];
  logic [PIX_W-1:0]  prior_row2 [MAX_WIDTH];
  logic [PIX_W-1:0]  win_cols [6];
  int unsigned       scan_y;
  int unsigned       scan_x;

  out_item_t expected_pixels [$];

  int error_count    = 0;
  int pixels_in      = 0;
  int pixels_checked = 0;
  int frames_run     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holdoff_requests = 0;
  int holdoff_served   = 0;
  int hold_left        = 0;
  int idle_cycles      = 0;

  function automatic void reset_filter_model();
    width_reg  = FW_RST;
    height_reg = FH_RST;
    rgb_mode   = 1'b0;
    coef_rows[0] = COEF_OUTER_RST;
    coef_rows[1] = COEF_MID_RST;
    coef_rows[2] = COEF_OUTER_RST;
    foreach (prior_row[i]) begin
      prior_row[i]  = '0;
      prior_row2[i] = '0;
    end
    foreach (win_cols[i]) win_cols[i] = '0;
    scan_y = 0;
    scan_x = 0;
  endfunction

  // Advance the scan by one grid position and queue the filtered pixel, if any.
  function automatic void convolve_pixel(in_item_t px_in);
    int unsigned      w, h, r, c;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] col [3];
    logic [PIX_W-1:0] taps_px [3];
    logic [CH_W-1:0]  chan_val [3];
    out_item_t        res;
    shortint          tap;
    int               sum, q;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_reg;
    if (h < 1) h = 1;
    if (scan_x > w) begin
      scan_x = 0;
      scan_y++;
    end
    if (scan_y > h) scan_y = 0;
    r = scan_y;
    c = scan_x;

    px = '0;
    if (r < h && c < w) px = {px_in.in_chan2, px_in.in_chan1, px_in.in_chan0};
    if (c == 0) foreach (win_cols[i]) win_cols[i] = '0;

    if (c < w) begin
      col[0] = (r == 0) ? '0 : prior_row2[c];
      col[1] = prior_row[c];
      col[2] = px;
      prior_row2[c] = col[1];
      prior_row[c]  = px;
    end else begin
      foreach (col[i]) col[i] = '0;
    end
    // top of the frame: rows above it are padding
    if (r == 0) begin
      col[0] = '0;
      col[1] = '0;
    end

    if (r >= 1 && c >= 1) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        sum = 0;
        for (int k = 0; k < 3; k++) begin
          taps_px[0] = win_cols[k];
          taps_px[1] = win_cols[3 + k];
          taps_px[2] = col[k];
          for (int l = 0; l < 3; l++) begin
            tap = coef_rows[k][TAP_W*l +: TAP_W];
            sum += int'(taps_px[l][CH_W*ch +: CH_W]) * int'(tap);
          end
        end
        q = (sum < 0) ? 0 : (sum >>> FRAC_W);
        if (q > 255) q = 255;
        chan_val[ch] = (ch == 0 || rgb_mode) ? q[CH_W-1:0] : '0;
      end
      res.out_chan0  = chan_val[0];
      res.out_chan1  = chan_val[1];
      res.out_chan2  = chan_val[2];
      res.last_pixel = (r == h && c == w);
      expected_pixels.push_back(res);
    end

    for (int k = 0; k < 3; k++) begin
      win_cols[k]     = win_cols[3 + k];
      win_cols[3 + k] = col[k];
    end

    if (c >= w) begin
      scan_x = 0;
      scan_y = (r >= h) ? 0 : r + 1;
    end else begin
      scan_x = c + 1;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      convolve_pixel(in_data);
      pixels_in++;
    end
  end

  task automatic report_mismatch(string field, int exp_val, int act_val);
    $error("%s mismatch: expected %0d, got %0d", field, exp_val, act_val);
    error_count++;
  endtask

  always @(posedge clk) begin
    out_item_t exp_px;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("filtered pixel transfer with nothing expected");
        error_count++;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (out_data.out_chan0 !== exp_px.out_chan0)
          report_mismatch("out_chan0", exp_px.out_chan0, out_data.out_chan0);
        if (out_data.out_chan1 !== exp_px.out_chan1)
          report_mismatch("out_chan1", exp_px.out_chan1, out_data.out_chan1);
        if (out_data.out_chan2 !== exp_px.out_chan2)
          report_mismatch("out_chan2", exp_px.out_chan2, out_data.out_chan2);
        if (out_data.last_pixel !== exp_px.last_pixel)
          report_mismatch("last_pixel", exp_px.last_pixel, out_data.last_pixel);
        pixels_checked++;
      end
    end
  end

  // Output side: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holdoff_served < holdoff_requests) begin
      out_stall      <= 1'b1;
      hold_left      <= HOLDOFF_CYCLES - 1;
      holdoff_served <= holdoff_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_conv3x3_image_filter: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic send_pixel(in_item_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_pixels(int count);
    logic [PIX_W-1:0] raw;
    repeat (count) begin
      raw = PIX_W'($urandom);
      send_pixel(raw);
    end
  endtask

  // Stop sending and wait until every filtered pixel is back and the pipe is empty.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [FW_W-1:0] fw, input logic [ROW_W-1:0] fh,
                           input bit rgb, input logic [COEF_W-1:0] top,
                           input logic [COEF_W-1:0] mid, input logic [COEF_W-1:0] bot);
    logic [CFG_DATA_W-1:0] vals [6];
    cfg_reg_t              idx;
    vals = '{CFG_DATA_W'(fw), CFG_DATA_W'(fh), CFG_DATA_W'(rgb), top, mid, bot};
    for (int i = 0; i < 6; i++) begin
      idx = cfg_reg_t'(i);
      cfg_wr_en <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en  <= 1'b0;
    width_reg  = fw;
    height_reg = fh;
    rgb_mode   = rgb;
    coef_rows[0] = top;
    coef_rows[1] = mid;
    coef_rows[2] = bot;
  endtask

  // Mostly small signed taps so sums land inside 0..255, some raw 16-bit words
  function automatic logic [COEF_W-1:0] random_kernel_row(bit middle);
    logic [COEF_W-1:0] row;
    int                t;
    if ($urandom_range(4) == 0) return middle ? COEF_MID_RST : COEF_OUTER_RST;
    for (int l = 0; l < 3; l++) begin
      if ($urandom_range(3) == 0) t = $urandom_range(16'hFFFF);
      else t = int'($urandom_range(4096)) - 1024;
      row[TAP_W*l +: TAP_W] = t[TAP_W-1:0];
    end
    return row;
  endfunction

  task automatic test_grey_checkerboard();
    in_item_t px;
    set_idling(0, 0);
    configure(3, 2, 1'b0, COEF_OUTER_RST, COEF_MID_RST, COEF_OUTER_RST);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        px.in_chan0 = ((r + c) % 2) ? 8'hFF : 8'h00;
        px.in_chan1 = 8'hFF;
        px.in_chan2 = 8'hA5;
        send_pixel(px);
      end
    end
    drain_results();
    frames_run++;
  endtask

  // Width and height of zero act as one: a 2x2 grid with a single output pixel
  task automatic test_tiny_extreme_taps();
    logic [COEF_W-1:0] kernels [4];
    in_item_t          px;
    kernels = '{48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h0, COEF_OUTER_RST};
    set_idling(0, 0);
    for (int i = 0; i < 4; i++) begin
      configure(0, 0, i != 3, kernels[i], kernels[i], kernels[i]);
      for (int j = 0; j < 4; j++) begin
        px = (j == 0) ? 24'hFF_FF_FF : 24'h01_80_FE;
        send_pixel(px);
      end
      drain_results();
      frames_run++;
    end
  endtask

  // Leave the scan beyond a shrunk grid, then the tallest frame cut short
  task automatic test_scan_overrun();
    set_idling(85, 0);
    configure(6, 4, 1'b1, random_kernel_row(0), random_kernel_row(1), random_kernel_row(0));
    send_random_pixels(10);
    drain_results();
    configure(2, 1, 1'b0, COEF_OUTER_RST, COEF_MID_RST, COEF_OUTER_RST);
    send_random_pixels(12);
    drain_results();
    configure(3, 16'hFFFF, 1'b1, random_kernel_row(0), random_kernel_row(1),
              random_kernel_row(0));
    send_random_pixels(40);
    drain_results();
    configure(3, 2, 1'b1, COEF_OUTER_RST, COEF_MID_RST, COEF_OUTER_RST);
    send_random_pixels(12);
    drain_results();
    frames_run += 4;
  endtask

  // Hold the output long enough for the filter to fill and stall its input
  task automatic test_output_holdoff();
    set_idling(0, 0);
    configure(8, 6, 1'b1, random_kernel_row(0), random_kernel_row(1), random_kernel_row(0));
    holdoff_requests++;
    send_random_pixels(9 * 7);
    drain_results();
    frames_run++;
  endtask

  task automatic test_random_frames();
    int sent, fw, fh, total, split, frame_no;
    sent     = 0;
    frame_no = 0;
    while (sent < RANDOM_ITEMS) begin
      case (frame_no % 4)
        0:       set_idling(0, 0);
        1:       set_idling(85, 0);
        2:       set_idling(0, 85);
        default: set_idling(13, 13);
      endcase
      fw = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      fh = $urandom_range(1, 8);
      total = (fw + 1) * (fh + 1);
      configure(FW_W'(fw), ROW_W'(fh), 1'($urandom_range(1)), random_kernel_row(0),
                random_kernel_row(1), random_kernel_row(0));
      if ($urandom_range(4) == 0) begin
        // swap kernel and mode partway through the frame
        split = $urandom_range(1, total - 1);
        send_random_pixels(split);
        drain_results();
        configure(FW_W'(fw), ROW_W'(fh), 1'($urandom_range(1)), random_kernel_row(0),
                  random_kernel_row(1), random_kernel_row(0));
        send_random_pixels(total - split);
      end else begin
        send_random_pixels(total);
      end
      drain_results();
      sent += total;
      frame_no++;
      frames_run++;
    end
  endtask

  initial begin
    reset_filter_model();
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_grey_checkerboard();
    test_tiny_extreme_taps();
    test_scan_overrun();
    test_output_holdoff();
    test_random_frames();

    drain_results();
    $display("Covered %0d frames: %0d pixels scanned, %0d filtered pixels checked,",
             frames_run, pixels_in, pixels_checked);
    $display("grey and RGB, clamped sizes, extreme taps, scan overrun, stalls.");
    if (error_count == 0) begin
      $display("tb_conv3x3_image_filter: done, clean");
    end else begin
      $display("tb_conv3x3_image_filter: done, errors");
    end
    $finish;
  end

endmodule

### conv3x3_image_filter.f
+incdir+rtl
rtl/cif_pkg.sv
rtl/cif_ram.sv
rtl/conv3x3_image_filter.sv
bench/tb_conv3x3_image_filter.sv
